/* src/unsigned_decimal_field_formatter_macros.svh */
// assertion macros for the unsigned decimal field formatter
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

// same-cycle implication
`define UDFF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UDFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/udff_pkg.sv */
// shared types and constants for the unsigned decimal field formatter
`default_nettype none

package udff_pkg;

   localparam int VALUE_W    = 64;
   localparam int BCD_DIGITS = 20;
   localparam int BCD_W      = BCD_DIGITS * 4;
   localparam int LEN_W      = 5;
   localparam int FIELD_W    = 6;
   localparam int PREC_W     = 7;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ALIGN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PAD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_FLAG  = 3'd4;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

   // precision code for an explicit zero precision
   localparam logic [PREC_W-1:0] PREC_EXPLICIT_ZERO = 7'h7F;

   typedef struct packed {
      logic [FIELD_W-1:0] field_width;
      logic [PREC_W-1:0]  precision;
      logic               left_align;
      logic               zero_pad;
      logic               space_flag;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic norm;
      logic setup;
      logic emit_pre;
      logic emit_dig;
      logic emit_post;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic norm_done;
      logic pre_zero;
      logic dig_zero;
      logic post_zero;
   } status_type;

endpackage

`default_nettype wire

/* src/udff_ctrl.sv */
// sequencing state machine of the unsigned decimal field formatter
`default_nettype none

module udff_ctrl
   import udff_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            busy
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_NORM  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_PRE   = 3'd4;
   localparam logic [2:0] ST_DIG   = 3'd5;
   localparam logic [2:0] ST_POST  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_last) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_SETUP;
            else cmd.norm = 1'b1;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_PRE;
         end
         ST_PRE: begin
            if (status.pre_zero) state_in = ST_DIG;
            else cmd.emit_pre = 1'b1;
         end
         ST_DIG: begin
            if (status.dig_zero) state_in = ST_POST;
            else cmd.emit_dig = 1'b1;
         end
         ST_POST: begin
            if (status.post_zero) state_in = ST_IDLE;
            else cmd.emit_post = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* src/udff_datapath.sv */
// conversion, field layout and character output of the formatter
`default_nettype none

module udff_datapath
   import udff_pkg::*;
#(
   parameter int MAX_FIELD = 63
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire cfg_type            cfg,
   input  wire logic [VALUE_W-1:0] req_value,
   output status_type              status,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_char_out,
   output logic                    rsp_last_char,
   output logic [FIELD_W-1:0]      rsp_total_count
);

   localparam logic [FIELD_W-1:0] W_MAX = FIELD_W'(MAX_FIELD);
   localparam logic signed [PREC_W-1:0] P_MAX = PREC_W'(MAX_FIELD);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [5:0]         bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               is_zero_ff, is_zero_in;
   logic [FIELD_W-1:0] pre_cnt_ff, pre_cnt_in;
   logic [FIELD_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [FIELD_W-1:0] post_cnt_ff, post_cnt_in;
   logic [FIELD_W-1:0] out_cnt_ff, out_cnt_in;
   logic [FIELD_W-1:0] total_ff, total_in;

   logic               valid_ff, valid_in;
   logic               last_ff, last_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [FIELD_W-1:0] count_ff, count_in;

   logic [BCD_W-1:0]   bcd_adj;
   logic [3:0]         nib;

   logic [FIELD_W-1:0]        w_clamp;
   logic signed [PREC_W-1:0]  p_clamp;
   logic [FIELD_W-1:0]        len6;
   logic                      stop;
   logic                      p_gt_len;
   logic [FIELD_W-1:0]        dfield_prec;
   logic [FIELD_W-1:0]        w_or_len;
   logic [FIELD_W-1:0]        dfield_zp;
   logic [FIELD_W-1:0]        dfield;
   logic [FIELD_W-1:0]        spaces;
   logic                      emit;

   // add-3 correction on every bcd digit ahead of the shift
   always_comb begin
      nib = '0;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         nib = bcd_ff[d*4 +: 4];
         bcd_adj[d*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // field layout, used in the setup cycle
   always_comb begin
      w_clamp  = (cfg.field_width > W_MAX) ? W_MAX : cfg.field_width;
      p_clamp  = ($signed(cfg.precision) > P_MAX) ? P_MAX : $signed(cfg.precision);
      len6     = FIELD_W'(len_ff);
      stop     = (p_clamp == $signed(PREC_EXPLICIT_ZERO)) && is_zero_ff;
      p_gt_len = !p_clamp[PREC_W-1] && (p_clamp[FIELD_W-1:0] > len6);
      if (stop) dfield_prec = '0;
      else if (p_gt_len) dfield_prec = p_clamp[FIELD_W-1:0];
      else dfield_prec = len6;
      w_or_len  = (w_clamp > len6) ? w_clamp : len6;
      dfield_zp = w_or_len - FIELD_W'(cfg.space_flag);
      if (dfield_zp < len6) dfield_zp = len6;
      dfield = (cfg.zero_pad && (p_clamp == '0)) ? dfield_zp : dfield_prec;
      spaces = (w_clamp > dfield) ? w_clamp - dfield : '0;
   end

   assign emit = cmd.emit_pre || cmd.emit_dig || cmd.emit_post;

   always_comb begin
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      bit_cnt_in  = bit_cnt_ff;
      len_in      = len_ff;
      is_zero_in  = is_zero_ff;
      pre_cnt_in  = pre_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      post_cnt_in = post_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      total_in    = total_ff;
      char_in     = char_ff;
      count_in    = count_ff;
      valid_in    = emit;
      last_in     = emit && (out_cnt_ff == FIELD_W'(1));

      if (cmd.load) begin
         bin_in     = req_value;
         bcd_in     = '0;
         bit_cnt_in = '0;
         len_in     = LEN_W'(BCD_DIGITS);
         is_zero_in = (req_value == '0);
      end
      if (cmd.conv) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 6'd1;
      end
      // drop leading zero digits so the top digit is the first to print
      if (cmd.norm) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
         len_in = len_ff - LEN_W'(1);
      end
      if (cmd.setup) begin
         pre_cnt_in  = cfg.left_align ? '0 : spaces;
         post_cnt_in = cfg.left_align ? spaces : '0;
         dig_cnt_in  = dfield;
         out_cnt_in  = dfield + spaces;
         total_in    = dfield + spaces;
      end
      if (emit) begin
         out_cnt_in = out_cnt_ff - FIELD_W'(1);
         count_in   = last_in ? total_ff : '0;
         char_in    = ASCII_SPACE;
      end
      if (cmd.emit_pre) pre_cnt_in = pre_cnt_ff - FIELD_W'(1);
      if (cmd.emit_post) post_cnt_in = post_cnt_ff - FIELD_W'(1);
      if (cmd.emit_dig) begin
         dig_cnt_in = dig_cnt_ff - FIELD_W'(1);
         if (dig_cnt_ff <= len6) begin
            char_in = ASCII_ZERO | CHAR_W'(bcd_ff[BCD_W-1 -: 4]);
            bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
         end else begin
            char_in = ASCII_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      len_ff      <= len_in;
      is_zero_ff  <= is_zero_in;
      pre_cnt_ff  <= pre_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      post_cnt_ff <= post_cnt_in;
      out_cnt_ff  <= out_cnt_in;
      total_ff    <= total_in;
      char_ff     <= char_in;
      count_ff    <= count_in;
   end

   assign status.conv_last = (bit_cnt_ff == 6'd63);
   assign status.norm_done = (bcd_ff[BCD_W-1 -: 4] != 4'd0) || (len_ff == LEN_W'(1));
   assign status.pre_zero  = (pre_cnt_ff == '0);
   assign status.dig_zero  = (dig_cnt_ff == '0);
   assign status.post_zero = (post_cnt_ff == '0);

   assign rsp_valid       = valid_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_last_char   = last_ff;
   assign rsp_total_count = count_ff;

endmodule

`default_nettype wire

/* src/unsigned_decimal_field_formatter.sv */
// Unsigned decimal field formatter: one 64-bit value in, its %u text out
// one ASCII character per cycle within each space/digit/space phase. The
// receiver cannot stall: each character is on rsp_* for exactly one cycle
// with rsp_valid high, and must be taken then. A transaction is taken when
// start is high and busy is low; busy stays high until the last character
// has left. A value passes through the serial binary-to-bcd converter (one
// input bit per cycle), the dropping of each leading zero digit, a setup
// step, and the space/digit/space phases that print the characters. An
// explicit zero precision on the value zero with field width zero prints
// nothing and gives no transaction on rsp_*. Registers must be written
// through csr_* only while busy is low, which the block does not enforce;
// csr_ready is always high and indexes past space_flag are dropped.
`default_nettype none

module unsigned_decimal_field_formatter
   import udff_pkg::*;
#(
   parameter int MAX_FIELD = 63
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input transaction
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [VALUE_W-1:0]    req_value,
   // result transaction, one per character
   output logic                       rsp_valid,
   output logic [CHAR_W-1:0]          rsp_char_out,
   output logic                       rsp_last_char,
   output logic [FIELD_W-1:0]         rsp_total_count,
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

`include "unsigned_decimal_field_formatter_macros.svh"

   // configuration registers, all reset to zero
   logic [FIELD_W-1:0] field_width_ff, field_width_in;
   logic [PREC_W-1:0]  precision_ff, precision_in;
   logic               left_align_ff, left_align_in;
   logic               zero_pad_ff, zero_pad_in;
   logic               space_flag_ff, space_flag_in;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      field_width_in = field_width_ff;
      precision_in   = precision_ff;
      left_align_in  = left_align_ff;
      zero_pad_in    = zero_pad_ff;
      space_flag_in  = space_flag_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FIELD_WIDTH: field_width_in = csr_wdata[FIELD_W-1:0];
            CSR_PRECISION:   precision_in   = csr_wdata[PREC_W-1:0];
            CSR_LEFT_ALIGN:  left_align_in  = csr_wdata[0];
            CSR_ZERO_PAD:    zero_pad_in    = csr_wdata[0];
            CSR_SPACE_FLAG:  space_flag_in  = csr_wdata[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= '0;
         precision_ff   <= '0;
         left_align_ff  <= 1'b0;
         zero_pad_ff    <= 1'b0;
         space_flag_ff  <= 1'b0;
      end else begin
         field_width_ff <= field_width_in;
         precision_ff   <= precision_in;
         left_align_ff  <= left_align_in;
         zero_pad_ff    <= zero_pad_in;
         space_flag_ff  <= space_flag_in;
      end
   end

   assign cfg.field_width = field_width_ff;
   assign cfg.precision   = precision_ff;
   assign cfg.left_align  = left_align_ff;
   assign cfg.zero_pad    = zero_pad_ff;
   assign cfg.space_flag  = space_flag_ff;

   // sequencer: convert, normalize, lay out the field, then emit
   udff_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // converter, digit store and registered character output
   udff_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_value       (req_value),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_char   (rsp_last_char),
      .rsp_total_count (rsp_total_count)
   );

   // characters only come out while a transaction is in flight
   `UDFF_ASSERT_IMPL(a_rsp_only_busy, clock, reset, rsp_valid, busy, "character while idle")
   // an accepted transaction keeps the block busy in the next cycle
   `UDFF_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   // the last-character mark never stands without a character
   `UDFF_ASSERT_IMPL(a_last_valid, clock, reset, rsp_last_char, rsp_valid, "stray last mark")
   // the count is only carried on the last character
   `UDFF_ASSERT_IMPL(a_count_last, clock, reset, rsp_valid && !rsp_last_char,
                     rsp_total_count == 6'd0, "count before last character")

endmodule

`default_nettype wire
